// ===== rtl/core/four_register_load_store_cpu_step_defines.svh =====
// Assertion macros shared by the checker of the load/store step core
`ifndef FOUR_REGISTER_LOAD_STORE_CPU_STEP_DEFINES_SVH
`define FOUR_REGISTER_LOAD_STORE_CPU_STEP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define FRLS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frls check failed");

// Next-cycle implication, disabled while reset is held
`define FRLS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frls check failed");

`endif

// ===== rtl/core/frlscs_pkg.sv =====
// Shared types, codes and microcode table of the load/store step core
package frlscs_pkg;

  // Stream word layout
  localparam int IN_W  = 120;
  localparam int OUT_W = 104;

  // Opcodes
  localparam logic [3:0] OP_ADD     = 4'd1;
  localparam logic [3:0] OP_SUB     = 4'd2;
  localparam logic [3:0] OP_MUL     = 4'd3;
  localparam logic [3:0] OP_DIV     = 4'd4;
  localparam logic [3:0] OP_LOAD    = 4'd8;
  localparam logic [3:0] OP_STORE   = 4'd9;
  localparam logic [3:0] OP_PRELOAD = 4'd14;
  localparam logic [3:0] OP_READ    = 4'd15;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ILLEGAL = 3'd1;
  localparam logic [2:0] ST_DIVZERO = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_HALTED  = 3'd4;

  // Micro-operations driving the datapath
  typedef enum logic [4:0] {
    U_WAIT    = 5'd0,
    U_RDA     = 5'd1,
    U_RDB     = 5'd2,
    U_EXEC    = 5'd3,
    U_DIVINIT = 5'd4,
    U_DIVSTEP = 5'd5,
    U_DIVFIX  = 5'd6,
    U_WBREG   = 5'd7,
    U_MEMRDS  = 5'd8,
    U_LDWB    = 5'd9,
    U_STRD    = 5'd10,
    U_STWR    = 5'd11,
    U_PRELOAD = 5'd12,
    U_MEMRDD  = 5'd13,
    U_RDWB    = 5'd14,
    U_ERR     = 5'd15,
    U_CLEAR   = 5'd16
  } uop_t;

  // Sequencing kinds
  typedef enum logic [2:0] {
    J_GOTO     = 3'd0,
    J_DISPATCH = 3'd1,
    J_IFDIV    = 3'd2,
    J_IFZERO   = 3'd3,
    J_UNTIL    = 3'd4
  } jmp_t;

  typedef logic [4:0] uaddr_t;

  // Microprogram addresses
  localparam uaddr_t A_IDLE    = 5'd0;
  localparam uaddr_t A_RDA     = 5'd1;
  localparam uaddr_t A_RDB     = 5'd2;
  localparam uaddr_t A_EXEC    = 5'd3;
  localparam uaddr_t A_DIVINIT = 5'd4;
  localparam uaddr_t A_DIVSTEP = 5'd5;
  localparam uaddr_t A_DIVFIX  = 5'd6;
  localparam uaddr_t A_WBREG   = 5'd7;
  localparam uaddr_t A_MEMRDS  = 5'd8;
  localparam uaddr_t A_LDWB    = 5'd9;
  localparam uaddr_t A_STRD    = 5'd10;
  localparam uaddr_t A_STWR    = 5'd11;
  localparam uaddr_t A_PRELOAD = 5'd12;
  localparam uaddr_t A_MEMRDD  = 5'd13;
  localparam uaddr_t A_RDWB    = 5'd14;
  localparam uaddr_t A_ERR     = 5'd15;
  localparam uaddr_t A_CLEAR   = 5'd16;

  // One control word: operation, sequencing, result emit, jump target
  typedef struct packed {
    uop_t   uop;
    jmp_t   jmp;
    logic   emit;
    uaddr_t nxt;
  } ucw_t;

  // Microcode read-only table
  function automatic ucw_t ucode(input uaddr_t a);
    ucw_t w;
    w = '{U_WAIT, J_DISPATCH, 1'b0, A_IDLE};
    case (a)
      A_IDLE:    w = '{U_WAIT,    J_DISPATCH, 1'b0, A_IDLE};
      A_RDA:     w = '{U_RDA,     J_GOTO,     1'b0, A_RDB};
      A_RDB:     w = '{U_RDB,     J_IFDIV,    1'b0, A_DIVINIT};
      A_EXEC:    w = '{U_EXEC,    J_GOTO,     1'b0, A_WBREG};
      A_DIVINIT: w = '{U_DIVINIT, J_IFZERO,   1'b0, A_ERR};
      A_DIVSTEP: w = '{U_DIVSTEP, J_UNTIL,    1'b0, A_DIVFIX};
      A_DIVFIX:  w = '{U_DIVFIX,  J_GOTO,     1'b0, A_WBREG};
      A_WBREG:   w = '{U_WBREG,   J_GOTO,     1'b1, A_IDLE};
      A_MEMRDS:  w = '{U_MEMRDS,  J_GOTO,     1'b0, A_LDWB};
      A_LDWB:    w = '{U_LDWB,    J_GOTO,     1'b1, A_IDLE};
      A_STRD:    w = '{U_STRD,    J_GOTO,     1'b0, A_STWR};
      A_STWR:    w = '{U_STWR,    J_GOTO,     1'b1, A_IDLE};
      A_PRELOAD: w = '{U_PRELOAD, J_GOTO,     1'b1, A_IDLE};
      A_MEMRDD:  w = '{U_MEMRDD,  J_GOTO,     1'b0, A_RDWB};
      A_RDWB:    w = '{U_RDWB,    J_GOTO,     1'b1, A_IDLE};
      A_ERR:     w = '{U_ERR,     J_GOTO,     1'b1, A_IDLE};
      A_CLEAR:   w = '{U_CLEAR,   J_UNTIL,    1'b0, A_IDLE};
      default:   w = '{U_WAIT,    J_GOTO,     1'b0, A_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/four_register_load_store_cpu_step.sv =====
// Top level: microcoded single-instruction step over a small register file and data memory
//
// Takes one decoded instruction per input word and returns one result word. After reset the
// block sweeps all MEM_WORDS words of the data memory to zero, one word per cycle; in_tready
// stays low until the sweep is done. A microcode table steps a plain datapath with one
// register-file read port, one memory write port and one registered memory read port. A new
// instruction is accepted only in the idle step, once the last one is through. Divide runs
// the one-bit-per-cycle restoring divider, which sets the worst case; a divide by zero skips
// it. A result sits in an output register, so the next instruction is accepted while it
// waits; a step that produces a result holds only when that register is still full and not
// drained.
module four_register_load_store_cpu_step #(
  parameter int MEM_WORDS = 128,
  parameter int REG_COUNT = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // opcode[3:0], dest_index[19:4], first_source[35:20], second_source[51:36],
  // preload_word[115:52], zero fill[119:116]
  input  logic [frlscs_pkg::IN_W-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // status[2:0], register_value[34:3], memory_value[98:35], zero fill[103:99]
  output logic [frlscs_pkg::OUT_W-1:0] out_tdata
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // Input word fields
  logic [3:0]  op_in;
  logic [15:0] dest_in;
  logic [15:0] src1_in;
  logic [15:0] src2_in;
  logic [63:0] word_in;

  assign op_in   = in_tdata[3:0];
  assign dest_in = in_tdata[19:4];
  assign src1_in = in_tdata[35:20];
  assign src2_in = in_tdata[51:36];
  assign word_in = in_tdata[115:52];

  // Sequencer
  frlscs_pkg::uaddr_t upc_r, upc_nxt;
  frlscs_pkg::ucw_t   ucw;
  logic               stall;
  logic               in_fire;
  logic               last_c;

  // Latched instruction
  logic [3:0]  op_r;
  logic [15:0] dest_r;
  logic [15:0] src1_r;
  logic [15:0] src2_r;
  logic [63:0] word_r;
  logic [2:0]  err_r;
  logic        halt_r;

  // Datapath registers
  logic [31:0] opa_r;
  logic [31:0] opb_r;
  logic [31:0] res_r;
  logic [31:0] rem_r;
  logic        neg_r;
  logic [4:0]  div_cnt_r;
  logic [AW-1:0] clr_cnt_r;

  // Register file and data memory
  logic [31:0] rf_r [REG_COUNT];
  logic [RW-1:0] rf_ra;
  logic [31:0] rf_rdata;
  logic [63:0] mem [MEM_WORDS];
  logic [63:0] mem_q_r;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;
  logic [63:0] mem_wd;

  // Dispatch decode
  frlscs_pkg::uaddr_t disp_addr;
  logic [2:0]  disp_err;
  logic        d_reg_ok, s1_reg_ok, s2_reg_ok, d_mem_ok, s1_mem_ok;

  // Arithmetic
  logic [31:0] exec_res;
  logic [32:0] div_shift;
  logic [32:0] div_diff;
  logic [63:0] st_word;

  // Output register
  logic                         out_tvalid_r;
  logic [frlscs_pkg::OUT_W-1:0] out_tdata_r;
  logic [2:0]                   emit_status;
  logic [31:0]                  emit_rv;
  logic [63:0]                  emit_mv;

  assign ucw       = frlscs_pkg::ucode(upc_r);
  assign in_tready = (upc_r == frlscs_pkg::A_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign stall     = ucw.emit && out_tvalid_r && !out_tready;

  // Range checks on the incoming index fields
  assign d_reg_ok  = ({1'b0, dest_in} < 17'(REG_COUNT));
  assign s1_reg_ok = ({1'b0, src1_in} < 17'(REG_COUNT));
  assign s2_reg_ok = ({1'b0, src2_in} < 17'(REG_COUNT));
  assign d_mem_ok  = ({1'b0, dest_in} < 17'(MEM_WORDS));
  assign s1_mem_ok = ({1'b0, src1_in} < 17'(MEM_WORDS));

  // Pick the microprogram entry for an accepted instruction
  always_comb begin
    disp_addr = frlscs_pkg::A_ERR;
    disp_err  = frlscs_pkg::ST_OK;
    if (halt_r) begin
      disp_err = frlscs_pkg::ST_HALTED;
    end else begin
      unique case (op_in) inside
        frlscs_pkg::OP_ADD, frlscs_pkg::OP_SUB, frlscs_pkg::OP_MUL, frlscs_pkg::OP_DIV: begin
          if (d_reg_ok && s1_reg_ok && s2_reg_ok) disp_addr = frlscs_pkg::A_RDA;
          else disp_err = frlscs_pkg::ST_RANGE;
        end
        frlscs_pkg::OP_LOAD: begin
          if (d_reg_ok && s1_mem_ok) disp_addr = frlscs_pkg::A_MEMRDS;
          else disp_err = frlscs_pkg::ST_RANGE;
        end
        frlscs_pkg::OP_STORE: begin
          if (d_mem_ok && s1_reg_ok) disp_addr = frlscs_pkg::A_STRD;
          else disp_err = frlscs_pkg::ST_RANGE;
        end
        frlscs_pkg::OP_PRELOAD: begin
          if (d_mem_ok) disp_addr = frlscs_pkg::A_PRELOAD;
          else disp_err = frlscs_pkg::ST_RANGE;
        end
        frlscs_pkg::OP_READ: begin
          if (d_mem_ok) disp_addr = frlscs_pkg::A_MEMRDD;
          else disp_err = frlscs_pkg::ST_RANGE;
        end
        default: begin
          disp_err = frlscs_pkg::ST_ILLEGAL;
        end
      endcase
    end
  end

  // Loop-end conditions for the divider and the clearing sweep
  assign last_c = (ucw.uop == frlscs_pkg::U_CLEAR) ? (clr_cnt_r == AW'(MEM_WORDS - 1))
                                                   : (div_cnt_r == 5'd31);

  // Next micro address
  always_comb begin
    upc_nxt = upc_r;
    unique case (ucw.jmp)
      frlscs_pkg::J_GOTO:     upc_nxt = ucw.nxt;
      frlscs_pkg::J_DISPATCH: upc_nxt = in_fire ? disp_addr : upc_r;
      frlscs_pkg::J_IFDIV:    upc_nxt = (op_r == frlscs_pkg::OP_DIV) ? ucw.nxt : upc_r + 5'd1;
      frlscs_pkg::J_IFZERO:   upc_nxt = (opb_r == 32'd0) ? ucw.nxt : upc_r + 5'd1;
      frlscs_pkg::J_UNTIL:    upc_nxt = last_c ? ucw.nxt : upc_r;
      default:                upc_nxt = frlscs_pkg::A_IDLE;
    endcase
    if (stall) upc_nxt = upc_r;
  end

  // Register file read port
  assign rf_ra    = (ucw.uop == frlscs_pkg::U_RDB) ? src2_r[RW-1:0] : src1_r[RW-1:0];
  assign rf_rdata = rf_r[rf_ra];

  // ALU for add, sub and low half of multiply
  always_comb begin
    case (op_r)
      frlscs_pkg::OP_ADD: exec_res = opa_r + opb_r;
      frlscs_pkg::OP_SUB: exec_res = opa_r - opb_r;
      default:            exec_res = opa_r * opb_r;
    endcase
  end

  // Restoring divider step: opa_r shifts the dividend out and the quotient in
  assign div_shift = {rem_r, opa_r[31]};
  assign div_diff  = div_shift - {1'b0, opb_r};
  assign st_word   = {{32{opa_r[31]}}, opa_r};

  // Memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = dest_r[AW-1:0];
    mem_wd = word_r;
    mem_ra = dest_r[AW-1:0];
    case (ucw.uop) inside
      frlscs_pkg::U_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = 64'd0;
      end
      frlscs_pkg::U_STWR: begin
        mem_we = !stall;
        mem_wd = st_word;
      end
      frlscs_pkg::U_PRELOAD: begin
        mem_we = !stall;
      end
      // Keep the load address while the loaded word waits for the output
      frlscs_pkg::U_MEMRDS, frlscs_pkg::U_LDWB: begin
        mem_ra = src1_r[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Data memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q_r <= mem[mem_ra];
  end

  // Result fields for the emitting steps
  always_comb begin
    emit_status = frlscs_pkg::ST_OK;
    emit_rv     = 32'd0;
    emit_mv     = 64'd0;
    case (ucw.uop)
      frlscs_pkg::U_WBREG:   emit_rv = res_r;
      frlscs_pkg::U_LDWB: begin
        emit_rv = mem_q_r[31:0];
        emit_mv = mem_q_r;
      end
      frlscs_pkg::U_STWR:    emit_mv = st_word;
      frlscs_pkg::U_PRELOAD: emit_mv = word_r;
      frlscs_pkg::U_RDWB:    emit_mv = mem_q_r;
      frlscs_pkg::U_ERR:     emit_status = err_r;
      default: begin
      end
    endcase
  end

  // Latch the instruction and run the datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= op_in;
      dest_r <= dest_in;
      src1_r <= src1_in;
      src2_r <= src2_in;
      word_r <= word_in;
      err_r  <= disp_err;
    end
    case (ucw.uop) inside
      frlscs_pkg::U_RDA, frlscs_pkg::U_STRD: opa_r <= rf_rdata;
      frlscs_pkg::U_RDB:  opb_r <= rf_rdata;
      frlscs_pkg::U_EXEC: res_r <= exec_res;
      frlscs_pkg::U_DIVINIT: begin
        opa_r     <= opa_r[31] ? 32'd0 - opa_r : opa_r;
        opb_r     <= opb_r[31] ? 32'd0 - opb_r : opb_r;
        neg_r     <= opa_r[31] ^ opb_r[31];
        rem_r     <= 32'd0;
        div_cnt_r <= 5'd0;
        if (opb_r == 32'd0) err_r <= frlscs_pkg::ST_DIVZERO;
      end
      frlscs_pkg::U_DIVSTEP: begin
        rem_r     <= div_diff[32] ? div_shift[31:0] : div_diff[31:0];
        opa_r     <= {opa_r[30:0], ~div_diff[32]};
        div_cnt_r <= div_cnt_r + 5'd1;
      end
      frlscs_pkg::U_DIVFIX: res_r <= neg_r ? 32'd0 - opa_r : opa_r;
      default: begin
      end
    endcase
  end

  // Control state, register file and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r        <= frlscs_pkg::A_CLEAR;
      halt_r       <= 1'b0;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) rf_r[i] <= 32'd0;
    end else begin
      upc_r <= upc_nxt;
      if (ucw.uop == frlscs_pkg::U_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      // Register writeback, clear-all on store and halt on an illegal opcode
      if (!stall) begin
        case (ucw.uop)
          frlscs_pkg::U_WBREG: rf_r[dest_r[RW-1:0]] <= res_r;
          frlscs_pkg::U_LDWB:  rf_r[dest_r[RW-1:0]] <= mem_q_r[31:0];
          frlscs_pkg::U_STWR:  for (int i = 0; i < REG_COUNT; i++) rf_r[i] <= 32'd0;
          frlscs_pkg::U_ERR:   if (err_r == frlscs_pkg::ST_ILLEGAL) halt_r <= 1'b1;
          default: begin
          end
        endcase
      end
      // Load a new result or drop a delivered one
      if (ucw.emit && !stall) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (ucw.emit && !stall) begin
      out_tdata_r <= {5'd0, emit_mv, emit_rv, emit_status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== rtl/core/frlscs_chk.sv =====
// Port checker for the load/store step core, bound to its top level
`include "four_register_load_store_cpu_step_defines.svh"

module frlscs_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  // status[2:0], register_value[34:3], memory_value[98:35], zero fill[103:99]
  input logic [frlscs_pkg::OUT_W-1:0] out_tdata
);

  // Hold a stalled result word
`FRLS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // One instruction at a time: no accept right after an accept
`FRLS_ASSERT_NXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)

  // Status stays within its defined codes
`FRLS_ASSERT_IMP(a_status_code, out_tvalid, out_tdata[2:0] <= frlscs_pkg::ST_HALTED)

  // Failed instructions carry zero values
`FRLS_ASSERT_IMP(a_err_zero, out_tvalid && (out_tdata[2:0] != frlscs_pkg::ST_OK), out_tdata[98:3] == 96'd0)

endmodule

bind four_register_load_store_cpu_step frlscs_chk u_frlscs_chk (.*);
